// ===== hdl/flow_tcp_state_tracker_unit_macros.svh =====
// Assertion helpers used by the checker module.
// They expect signals named clk and arst_n in the enclosing scope.
`ifndef FLOW_TCP_STATE_TRACKER_UNIT_MACROS_SVH
`define FLOW_TCP_STATE_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FTST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define FTST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ftst_pkg.sv =====
package ftst_pkg;

	// Table geometry
	localparam int FLOWS   = 1024;
	localparam int IDX_W   = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int SLOT_W  = 10;
	localparam int FLOWS_W = $clog2(FLOWS + 1);

	// Slot reduction by reciprocal: q = (slot * RECIP) >> RECIP_SH, off by at most one
	localparam int RECIP_SH = 20;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << RECIP_SH) / FLOWS);
	localparam logic [FLOWS_W-1:0] FLOWS_C = FLOWS_W'(FLOWS);

	// Transport codes
	localparam logic [1:0] TR_TCP = 2'd0;
	localparam logic [1:0] TR_UDP = 2'd1;

	// TCP flag bit positions
	localparam int FLAG_FIN = 0;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_RST = 2;
	localparam int FLAG_ACK = 4;

	// Connection state codes
	localparam logic [2:0] ST_NEW      = 3'd0;
	localparam logic [2:0] ST_SYN_SENT = 3'd1;
	localparam logic [2:0] ST_SYN_RCVD = 3'd2;
	localparam logic [2:0] ST_ESTAB    = 3'd3;
	localparam logic [2:0] ST_FIN_WAIT = 3'd4;
	localparam logic [2:0] ST_CLOSED   = 3'd5;
	localparam logic [2:0] ST_RESET    = 3'd6;
	localparam logic [2:0] ST_UNKNOWN  = 3'd7;

	// Record mark bit positions
	localparam int MARK_DONE  = 0;
	localparam int MARK_SYN   = 1;
	localparam int MARK_FIN_A = 2;
	localparam int MARK_FIN_B = 3;

	// Input beat
	typedef struct packed {
		logic [SLOT_W-1:0] flow_slot;
		logic              new_flow;
		logic [1:0]        transport;
		logic              forward;
		logic [7:0]        tcp_flags;
		logic [31:0]       seq_number;
		logic [15:0]       payload_len;
		logic [15:0]       frame_len;
	} pkt_t;

	// Result beat
	typedef struct packed {
		logic [SLOT_W-1:0] slot_out;
		logic [2:0]        conn_state;
		logic              done_flag;
		logic              was_retransmit;
		logic [7:0]        flags_union;
		logic [31:0]       dir_packets;
		logic [47:0]       dir_bytes;
		logic [47:0]       dir_payload;
		logic [31:0]       dir_retransmits;
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic reduce;
		logic read;
		logic commit;
	} ftst_cmd_t;

endpackage

// ===== hdl/flow_tcp_state_tracker_unit.sv =====
// Per-flow TCP connection tracker.
// Input channel (pkt_valid / pkt_stall / pkt): one beat per packet header, naming
// the flow slot, transport, direction, flags, sequence number and lengths.
// A beat with new_flow set clears the slot's record before it is updated; the
// first beat for any slot after reset must carry new_flow.
// Result channel (res_valid / res_stall / res): one beat per packet with the
// updated state, flags union and the counters of the packet's direction.
// Each packet passes the controller's states for slot reduction, the registered
// record read and the read-modify-write; res_valid rises with the write-back.
// A new packet is taken only once the controller is back in idle after the
// previous packet's write-back, so packets are not overlapped.
// When the receiver stalls, the result holds and one further packet may be
// accepted and processed up to its write-back, which waits for the output.
// Reset clears the controller and output valid only; the record table keeps
// whatever it held.
module flow_tcp_state_tracker_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pkt_valid,
	output logic           pkt_stall,
	input  ftst_pkg::pkt_t pkt,
	output logic           res_valid,
	input  logic           res_stall,
	output ftst_pkg::res_t res
);
	import ftst_pkg::*;

	ftst_cmd_t cmd;

	ftst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd)
	);

	ftst_dp u_dp (
		.clk (clk),
		.cmd (cmd),
		.pkt (pkt),
		.res (res)
	);

endmodule

// ===== hdl/ftst_ctrl.sv =====
module ftst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pkt_valid,
	output logic                pkt_stall,
	output logic                res_valid,
	input  logic                res_stall,
	output ftst_pkg::ftst_cmd_t cmd
);
	import ftst_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_REDUCE = 4'b0010,
		S_READ   = 4'b0100,
		S_CALC   = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic   res_valid_q;
	logic   res_free;

	// Output register can take a new beat
	assign res_free = !res_valid_q || !res_stall;

	// Commands
	assign cmd.capture = (state_q == S_IDLE) && pkt_valid;
	assign cmd.reduce  = (state_q == S_REDUCE);
	assign cmd.read    = (state_q == S_READ);
	assign cmd.commit  = (state_q == S_CALC) && res_free;

	assign pkt_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (pkt_valid) state_nxt = S_REDUCE;
			end
			S_REDUCE: state_nxt = S_READ;
			S_READ:   state_nxt = S_CALC;
			S_CALC: begin
				if (res_free) state_nxt = S_IDLE;
			end
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/ftst_dp.sv =====
module ftst_dp (
	input  logic                clk,
	input  ftst_pkg::ftst_cmd_t cmd,
	input  ftst_pkg::pkt_t      pkt,
	output ftst_pkg::res_t      res
);
	import ftst_pkg::*;

	// One flow record
	typedef struct packed {
		logic [2:0]  state;
		logic [3:0]  marks;
		logic [7:0]  flag_union;
		logic [1:0]  seq_valid;
		logic [31:0] next_seq_a;
		logic [31:0] next_seq_b;
		logic [31:0] pkts_a;
		logic [31:0] pkts_b;
		logic [47:0] bytes_a;
		logic [47:0] bytes_b;
		logic [47:0] pay_a;
		logic [47:0] pay_b;
		logic [31:0] rtx_a;
		logic [31:0] rtx_b;
	} flow_rec_t;

	localparam int PROD_W = SLOT_W + RECIP_W;
	localparam int QF_W   = SLOT_W + FLOWS_W;

	function automatic logic [31:0] sat_inc32(input logic [31:0] a);
		logic [32:0] s;
		s = {1'b0, a} + 33'd1;
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {33'd0, b};
		return s[48] ? '1 : s[47:0];
	endfunction

	pkt_t              in_q;
	logic [SLOT_W-1:0] quo_q;
	logic [SLOT_W-1:0] slot_q;
	flow_rec_t         rd_q;
	res_t              res_q;
	flow_rec_t         mem [FLOWS];

	logic [PROD_W-1:0] prod;
	logic [QF_W-1:0]   qf, rem_est, rem;
	logic [SLOT_W-1:0] slot_r;

	flow_rec_t   cur, nrec;
	res_t        nres;
	logic        fwd, retr, v_old, v_new;
	logic [2:0]  st;
	logic [3:0]  mk, mk_fin;
	logic [31:0] pk_new, rt_old, rt_new, nseq_old, nseq_new, seq_end, diff;
	logic [47:0] by_new, pl_new;
	logic        syn, ack, fin, rst;

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= pkt;
	end

	// Slot reduction, step one: quotient estimate
	assign prod = PROD_W'(in_q.flow_slot) * PROD_W'(RECIP);
	always_ff @(posedge clk) begin
		if (cmd.reduce) quo_q <= prod[RECIP_SH +: SLOT_W];
	end

	// Slot reduction, step two: remainder with one correction
	assign qf      = QF_W'(quo_q) * QF_W'(FLOWS_C);
	assign rem_est = QF_W'(in_q.flow_slot) - qf;
	assign rem     = (rem_est >= QF_W'(FLOWS_C)) ? (rem_est - QF_W'(FLOWS_C)) : rem_est;
	assign slot_r  = rem[SLOT_W-1:0];

	// Record read, data registered
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			slot_q <= slot_r;
			rd_q   <= mem[IDX_W'(slot_r)];
		end
	end

	// Record update
	always_comb begin
		cur    = in_q.new_flow ? '0 : rd_q;
		nrec   = cur;
		fwd    = in_q.forward;
		syn    = in_q.tcp_flags[FLAG_SYN];
		ack    = in_q.tcp_flags[FLAG_ACK];
		fin    = in_q.tcp_flags[FLAG_FIN];
		rst    = in_q.tcp_flags[FLAG_RST];

		// per-direction counters
		pk_new   = sat_inc32(fwd ? cur.pkts_a : cur.pkts_b);
		by_new   = sat_add48(fwd ? cur.bytes_a : cur.bytes_b, in_q.frame_len);
		pl_new   = sat_add48(fwd ? cur.pay_a : cur.pay_b, in_q.payload_len);
		rt_old   = fwd ? cur.rtx_a : cur.rtx_b;
		nseq_old = fwd ? cur.next_seq_a : cur.next_seq_b;
		v_old    = fwd ? cur.seq_valid[0] : cur.seq_valid[1];
		seq_end  = in_q.seq_number + {16'd0, in_q.payload_len};
		diff     = seq_end - nseq_old;

		st       = cur.state;
		mk       = cur.marks;
		mk_fin   = cur.marks;
		retr     = 1'b0;
		rt_new   = rt_old;
		nseq_new = nseq_old;
		v_new    = v_old;

		if (in_q.transport == TR_TCP) begin
			nrec.flag_union = cur.flag_union | in_q.tcp_flags;
			// retransmission check on sequence end
			if (in_q.payload_len != 16'd0) begin
				if (!v_old) begin
					v_new    = 1'b1;
					nseq_new = seq_end;
				end else if (diff == 32'd0 || diff[31]) begin
					retr   = 1'b1;
					rt_new = sat_inc32(rt_old);
				end else begin
					nseq_new = seq_end;
				end
			end
			// connection state
			if (rst) begin
				st = ST_RESET;
				mk[MARK_DONE] = 1'b1;
			end else if (syn && !ack) begin
				mk[MARK_SYN] = 1'b1;
				if (st == ST_NEW) st = ST_SYN_SENT;
			end else if (syn && ack) begin
				if (st == ST_NEW || st == ST_SYN_SENT) st = ST_SYN_RCVD;
			end else if (fin) begin
				mk_fin = mk;
				mk_fin[MARK_DONE] = 1'b1;
				if (fwd) mk_fin[MARK_FIN_A] = 1'b1;
				else mk_fin[MARK_FIN_B] = 1'b1;
				mk = mk_fin;
				st = (mk_fin[MARK_FIN_A] && mk_fin[MARK_FIN_B]) ? ST_CLOSED : ST_FIN_WAIT;
			end else if (ack && (st == ST_NEW || st == ST_SYN_SENT || st == ST_SYN_RCVD)) begin
				st = ST_ESTAB;
			end
		end else if (in_q.transport == TR_UDP) begin
			if (st == ST_NEW) st = ST_ESTAB;
		end else begin
			st = ST_UNKNOWN;
		end

		nrec.state = st;
		nrec.marks = mk;
		if (fwd) begin
			nrec.pkts_a       = pk_new;
			nrec.bytes_a      = by_new;
			nrec.pay_a        = pl_new;
			nrec.rtx_a        = rt_new;
			nrec.next_seq_a   = nseq_new;
			nrec.seq_valid[0] = v_new;
		end else begin
			nrec.pkts_b       = pk_new;
			nrec.bytes_b      = by_new;
			nrec.pay_b        = pl_new;
			nrec.rtx_b        = rt_new;
			nrec.next_seq_b   = nseq_new;
			nrec.seq_valid[1] = v_new;
		end

		nres.slot_out        = slot_q;
		nres.conn_state      = st;
		nres.done_flag       = mk[MARK_DONE];
		nres.was_retransmit  = retr;
		nres.flags_union     = nrec.flag_union;
		nres.dir_packets     = pk_new;
		nres.dir_bytes       = by_new;
		nres.dir_payload     = pl_new;
		nres.dir_retransmits = rt_new;
	end

	// Write back
	always_ff @(posedge clk) begin
		if (cmd.commit) mem[IDX_W'(slot_q)] <= nrec;
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.commit) res_q <= nres;
	end

	assign res = res_q;

endmodule

// ===== hdl/ftst_checker.sv =====
`include "flow_tcp_state_tracker_unit_macros.svh"

module ftst_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pkt_valid,
	input logic           pkt_stall,
	input ftst_pkg::pkt_t pkt,
	input logic           res_valid,
	input logic           res_stall,
	input ftst_pkg::res_t res
);
	import ftst_pkg::*;

	logic pkt_acc;
	assign pkt_acc = pkt_valid && !pkt_stall;

	// A stalled packet beat holds
	`FTST_ASSERT_NEXT(a_pkt_hold, pkt_valid && pkt_stall, pkt_valid && $stable(pkt), "packet beat changed while stalled")

	// A stalled result beat holds
	`FTST_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result beat changed while stalled")

	// One packet in flight: the input stalls right after a beat is taken
	`FTST_ASSERT_NEXT(a_busy_after_accept, pkt_acc, pkt_stall, "input taken while a packet is in flight")

	// A rising result valid must trace back to an accepted packet
	`FTST_ASSERT_NOW(a_latency, $rose(res_valid), $past(pkt_acc, 4), "result without a packet before")

endmodule

bind flow_tcp_state_tracker_unit ftst_checker u_ftst_checker (.*);
